FILE: rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO with lookback read.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = 8;
  localparam int CNT_W  = 9;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_LOOK  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_OFFSET = 2'd3
  } status_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              clr;
  } store_req_t;

endpackage

FILE: rtl/brf_store.sv
// ----------------------------------------------------------------------------
// brf_store
// Ring byte store with one write and one registered read port. Per-entry
// valid flags make a cleared entry read as zero without a sweep.
// ----------------------------------------------------------------------------
module brf_store (
  input  logic                clk,
  input  logic                rst,
  input  brf_pkg::store_req_t req,
  output logic [7:0]          rd_data
);
  import brf_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [7:0]       mem_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    mem_q <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      vld_q <= vld[req.rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : 8'd0;

endmodule

FILE: rtl/brf_ctrl.sv
// ----------------------------------------------------------------------------
// brf_ctrl
// Input register, pointer and count state, status decode and result
// register for the byte ring FIFO.
// ----------------------------------------------------------------------------
module brf_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [1:0]                    in_mode,
  input  logic [7:0]                    in_byte,
  input  logic [7:0]                    in_offset,
  input  logic                          cfg_we,
  input  logic [brf_pkg::CNT_W-1:0]     cfg_value,
  output brf_pkg::store_req_t           req,
  output logic                          res_valid,
  output logic [1:0]                    res_status,
  output logic                          res_rd_ok,
  output logic [brf_pkg::CNT_W-1:0]     res_count,
  output logic                          res_empty,
  output logic                          res_full
);
  import brf_pkg::*;

  // input register
  logic              op_valid;
  logic [1:0]        op_mode;
  logic [7:0]        op_byte;
  logic [7:0]        op_offset;

  // fifo state
  logic [CNT_W-1:0]  cap;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] tail;
  logic [CNT_W-1:0]  count;

  logic [ADDR_W-1:0] head_next;
  logic [ADDR_W-1:0] tail_next;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  cap_next;
  status_t           status_next;
  logic              rd_ok_next;
  logic [CNT_W-1:0]  look_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= in_valid;
    end
    op_mode   <= in_mode;
    op_byte   <= in_byte;
    op_offset <= in_offset;
  end

  always_comb begin
    if (cfg_value == '0) begin
      cap_next = CNT_W'(1);
    end else if (cfg_value > CNT_W'(DEPTH)) begin
      cap_next = CNT_W'(DEPTH);
    end else begin
      cap_next = cfg_value;
    end
  end

  always_comb begin
    if (head >= op_offset) begin
      look_addr = {1'b0, head} - {1'b0, op_offset};
    end else begin
      look_addr = cap + {1'b0, head} - {1'b0, op_offset};
    end
  end

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    status_next = ST_OK;
    rd_ok_next  = 1'b0;
    req         = '0;
    if (op_valid) begin
      unique case (mode_t'(op_mode))
        MODE_PUSH: begin
          if (count >= cap) begin
            status_next = ST_FULL;
          end else begin
            req.wr_en   = 1'b1;
            req.wr_addr = tail;
            req.wr_data = op_byte;
            tail_next   = (({1'b0, tail} + CNT_W'(1)) == cap) ? '0 : tail + ADDR_W'(1);
            count_next  = count + CNT_W'(1);
          end
        end
        MODE_POP: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            req.rd_addr = head;
            rd_ok_next  = 1'b1;
            head_next   = (({1'b0, head} + CNT_W'(1)) == cap) ? '0 : head + ADDR_W'(1);
            count_next  = count - CNT_W'(1);
          end
        end
        MODE_LOOK: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else if ({1'b0, op_offset} >= cap) begin
            status_next = ST_OFFSET;
          end else begin
            req.rd_addr = look_addr[ADDR_W-1:0];
            rd_ok_next  = 1'b1;
          end
        end
        MODE_CLEAR: begin
          head_next  = '0;
          tail_next  = '0;
          count_next = '0;
          req.clr    = 1'b1;
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
    if (cfg_we) begin
      head_next  = '0;
      tail_next  = '0;
      count_next = '0;
      req.clr    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CNT_W'(DEPTH);
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cap_next;
      end
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      res_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= status_next;
    res_rd_ok  <= rd_ok_next;
    res_count  <= count_next;
    res_empty  <= (count_next == '0);
    res_full   <= (count_next == cap);
  end

endmodule

FILE: rtl/byte_ring_fifo_with_lookback_unit.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_lookback_unit
// Byte FIFO in a 256-entry ring with push, pop, lookback read and clear.
// ----------------------------------------------------------------------------
// One operation is taken in every clock cycle (busy stays low) and its result
// appears on the result ports with done high after passing the input register
// and then the pointer logic into the result register and the registered store
// read. Results cannot be held off, so sample them whenever done is high. The
// capacity register is always ready; a write empties the FIFO. Store clearing on
// reset, clear or a capacity write takes effect at once through per-entry valid
// flags, so there is no clearing pass.
module byte_ring_fifo_with_lookback_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                mode,
  input  logic [7:0]                push_byte,
  input  logic [7:0]                offset,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [brf_pkg::CNT_W-1:0] capacity,
  output logic                      done,
  output logic [1:0]                status,
  output logic [7:0]                read_byte,
  output logic [brf_pkg::CNT_W-1:0] fill_count,
  output logic                      is_empty,
  output logic                      is_full
);
  import brf_pkg::*;

  store_req_t req;
  logic       rd_ok;
  logic [7:0] rd_data;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  brf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .in_mode    (mode),
    .in_byte    (push_byte),
    .in_offset  (offset),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_value  (capacity),
    .req        (req),
    .res_valid  (done),
    .res_status (status),
    .res_rd_ok  (rd_ok),
    .res_count  (fill_count),
    .res_empty  (is_empty),
    .res_full   (is_full)
  );

  brf_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  assign read_byte = rd_ok ? rd_data : 8'd0;

endmodule

FILE: tb/tb_byte_ring_fifo_with_lookback_unit.sv
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_with_lookback_unit
// Self-checking bench for the byte ring FIFO with lookback read. A clocked
// driver sends queued operations with random idle gaps, a shadow copy of the
// ring predicts each result, and a clocked monitor compares every strobed
// result field by field. Runs go through many capacity settings, including
// zero and values past the store depth, with fill and drain bursts that hit
// full, empty and offset rejects.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_with_lookback_unit;
  import brf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    mode_t      op;
    logic [7:0] data;
    logic [7:0] offs;
    logic [7:0] gap;
    logic       hold;
  } fifo_op_t;

  typedef struct packed {
    status_t          st;
    logic [7:0]       rd;
    logic [CNT_W-1:0] cnt;
    logic             emp;
    logic             ful;
  } fifo_res_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       mode = MODE_PUSH;
  logic [7:0]       push_byte = 8'd0;
  logic [7:0]       offset = 8'd0;
  logic             cfg_valid = 1'b0;
  logic [CNT_W-1:0] capacity = 9'd256;
  logic             busy;
  logic             cfg_ready;
  logic             done;
  logic [1:0]       status;
  logic [7:0]       read_byte;
  logic [CNT_W-1:0] fill_count;
  logic             is_empty;
  logic             is_full;

  // shadow ring state
  logic [7:0]       shadow_bytes [DEPTH];
  int               shadow_head;
  int               shadow_tail;
  int               shadow_held;
  logic [CNT_W-1:0] shadow_cap = 9'd256;

  fifo_op_t  ops_to_send [$];
  fifo_res_t fifo_results_due [$];
  fifo_op_t  cur_op;
  fifo_res_t due_now;
  int        gap_left;
  bit        gap_armed;
  int        ops_queued;
  int        ops_accepted;
  int        results_checked;
  int        mismatches;
  int        cycle_count;
  int        cap_writes;
  int        n_full;
  int        n_empty;
  int        n_offset;

  byte_ring_fifo_with_lookback_unit uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .push_byte  (push_byte),
    .offset     (offset),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity),
    .done       (done),
    .status     (status),
    .read_byte  (read_byte),
    .fill_count (fill_count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void ring_wipe();
    for (int i = 0; i < DEPTH; i++) shadow_bytes[i] = 8'd0;
    shadow_head = 0;
    shadow_tail = 0;
    shadow_held = 0;
  endfunction

  function automatic int eff_capacity(input int v);
    if (v < 1) return 1;
    if (v > DEPTH) return DEPTH;
    return v;
  endfunction

  function automatic fifo_res_t ring_apply(input fifo_op_t t);
    fifo_res_t r;
    int        cap;
    int        addr;
    cap = eff_capacity(int'(shadow_cap));
    if (shadow_head >= cap) shadow_head = 0;
    if (shadow_tail >= cap) shadow_tail = 0;
    r.st = ST_OK;
    r.rd = 8'd0;
    case (t.op)
      MODE_PUSH: begin
        if (shadow_held >= cap) begin
          r.st = ST_FULL;
        end else begin
          shadow_bytes[shadow_tail] = t.data;
          shadow_tail = (shadow_tail + 1 == cap) ? 0 : shadow_tail + 1;
          shadow_held++;
        end
      end
      MODE_POP: begin
        if (shadow_held == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.rd = shadow_bytes[shadow_head];
          shadow_head = (shadow_head + 1 == cap) ? 0 : shadow_head + 1;
          shadow_held--;
        end
      end
      MODE_LOOK: begin
        if (shadow_held == 0) begin
          r.st = ST_EMPTY;
        end else if (int'(t.offs) >= cap) begin
          r.st = ST_OFFSET;
        end else begin
          addr = (shadow_head >= int'(t.offs)) ? shadow_head - int'(t.offs)
                                               : cap + shadow_head - int'(t.offs);
          r.rd = shadow_bytes[addr];
        end
      end
      default: ring_wipe();
    endcase
    r.cnt = shadow_held[CNT_W-1:0];
    r.emp = (shadow_held == 0);
    r.ful = (shadow_held == cap);
    return r;
  endfunction

  function automatic logic [7:0] rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'd0;
    if (r < 90) return 8'($urandom_range(1, 3));
    if (r < 97) return 8'($urandom_range(4, 8));
    return 8'($urandom_range(9, 40));
  endfunction

  function automatic logic [7:0] pick_offset(input int cap);
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 8'($urandom_range(0, cap - 1));
    if (r < 17) return 8'($urandom_range(0, 255));
    return (cap > 255) ? 8'd255 : 8'(cap);
  endfunction

  task automatic add_op(input mode_t op, input logic [7:0] data, input logic [7:0] offs,
                        input logic [7:0] gap, input logic hold);
    fifo_op_t t;
    t.op   = op;
    t.data = data;
    t.offs = offs;
    t.gap  = gap;
    t.hold = hold;
    ops_to_send.push_back(t);
    ops_queued++;
  endtask

  task automatic settle();
    while (ops_accepted != ops_queued || fifo_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    capacity  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // fill and drain bursts so the ring reaches both full and empty
  task automatic gen_random(input int n, input int cap, input bit steady);
    int    fill;
    bit    filling;
    int    r;
    mode_t op;
    fill    = 0;
    filling = 1'b1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 199);
      if (filling) begin
        op = (r < 160) ? MODE_PUSH : (r < 175) ? MODE_POP : (r < 199) ? MODE_LOOK : MODE_CLEAR;
      end else begin
        op = (r < 30) ? MODE_PUSH : (r < 170) ? MODE_POP : (r < 199) ? MODE_LOOK : MODE_CLEAR;
      end
      case (op)
        MODE_PUSH:  if (fill < cap) fill++;
        MODE_POP:   if (fill > 0) fill--;
        MODE_CLEAR: fill = 0;
        default: ;
      endcase
      if (filling && fill >= cap && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (!filling && fill == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      add_op(op, 8'($urandom_range(0, 255)), pick_offset(cap),
             steady ? 8'd0 : rand_gap(), (i == n / 2) || ($urandom_range(0, 199) == 0));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        shadow_cap = capacity;
        ring_wipe();
      end
      if (start && !busy) begin
        fifo_results_due.push_back(ring_apply(cur_op));
        ops_accepted++;
      end
      if (!start || !busy) begin
        if (ops_to_send.size() == 0) begin
          start <= 1'b0;
        end else begin
          if (!gap_armed) begin
            gap_left  = int'(ops_to_send[0].gap);
            gap_armed = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
          end else if (ops_to_send[0].hold && fifo_results_due.size() != 0) begin
            start <= 1'b0;
          end else begin
            cur_op    = ops_to_send.pop_front();
            gap_armed = 1'b0;
            start     <= 1'b1;
            mode      <= cur_op.op;
            push_byte <= cur_op.data;
            offset    <= cur_op.offs;
          end
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (fifo_results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with no transaction pending, expected none, actual status %0d",
                 $time, status);
      end else begin
        due_now = fifo_results_due.pop_front();
        results_checked++;
        case (due_now.st)
          ST_FULL:   n_full++;
          ST_EMPTY:  n_empty++;
          ST_OFFSET: n_offset++;
          default: ;
        endcase
        check_field("status", CNT_W'(due_now.st), CNT_W'(status));
        check_field("read_byte", CNT_W'(due_now.rd), CNT_W'(read_byte));
        check_field("fill_count", due_now.cnt, fill_count);
        check_field("is_empty", CNT_W'(due_now.emp), CNT_W'(is_empty));
        check_field("is_full", CNT_W'(due_now.ful), CNT_W'(is_full));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[byte_ring_fifo_with_lookback_unit] ERROR");
      $finish;
    end
  end

  int cap_plan  [11] = '{1, 2, 3, 7, 16, 100, 255, 256, 0, 300, 5};
  int size_plan [11] = '{60, 70, 70, 90, 120, 140, 110, 420, 50, 120, 60};

  initial begin
    int v;
    ring_wipe();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: empty rejects, byte extremes, wrapped lookback, clear
    add_op(MODE_POP,   8'h00, 8'd0,   rand_gap(), 1'b0);
    add_op(MODE_LOOK,  8'h00, 8'd0,   rand_gap(), 1'b0);
    add_op(MODE_PUSH,  8'h00, 8'd0,   rand_gap(), 1'b0);
    add_op(MODE_PUSH,  8'hFF, 8'd255, rand_gap(), 1'b0);
    add_op(MODE_LOOK,  8'h00, 8'd0,   rand_gap(), 1'b0);
    add_op(MODE_LOOK,  8'h00, 8'd255, rand_gap(), 1'b0);
    add_op(MODE_POP,   8'h00, 8'd0,   rand_gap(), 1'b0);
    add_op(MODE_POP,   8'h00, 8'd0,   rand_gap(), 1'b0);
    add_op(MODE_POP,   8'h00, 8'd0,   rand_gap(), 1'b0);
    add_op(MODE_PUSH,  8'h5A, 8'd0,   rand_gap(), 1'b0);
    add_op(MODE_CLEAR, 8'h00, 8'd0,   rand_gap(), 1'b0);
    add_op(MODE_LOOK,  8'h00, 8'd3,   rand_gap(), 1'b0);
    add_op(MODE_PUSH,  8'h3C, 8'd0,   rand_gap(), 1'b0);
    settle();

    // zero capacity acts as one; the write also empties the ring
    write_capacity(9'd0);
    add_op(MODE_PUSH, 8'h11, 8'd0, rand_gap(), 1'b0);
    add_op(MODE_PUSH, 8'h22, 8'd0, rand_gap(), 1'b0);
    add_op(MODE_LOOK, 8'h00, 8'd1, rand_gap(), 1'b0);
    add_op(MODE_LOOK, 8'h00, 8'd0, rand_gap(), 1'b0);
    add_op(MODE_POP,  8'h00, 8'd0, rand_gap(), 1'b0);
    add_op(MODE_POP,  8'h00, 8'd0, rand_gap(), 1'b0);
    settle();

    // capacity past the depth saturates
    write_capacity(9'd511);
    add_op(MODE_PUSH, 8'h80, 8'd0,   rand_gap(), 1'b0);
    add_op(MODE_LOOK, 8'h00, 8'd128, rand_gap(), 1'b0);
    settle();

    for (int p = 0; p < 11; p++) begin
      v = (cap_plan[p] == 300) ? $urandom_range(257, 511) : cap_plan[p];
      write_capacity(9'(v));
      gen_random(size_plan[p], eff_capacity(v), (p == 2) || (p == 6));
      settle();
    end

    $display("checked %0d results over %0d capacity settings", results_checked, cap_writes);
    $display("rejects seen: %0d full, %0d empty, %0d offset", n_full, n_empty, n_offset);
    if (mismatches == 0) begin
      $display("[byte_ring_fifo_with_lookback_unit] OK");
    end else begin
      $display("[byte_ring_fifo_with_lookback_unit] ERROR");
    end
    $finish;
  end

endmodule
